// ===== rtl/core/per_host_traffic_counter_table_core_defines.svh =====
// Assertion helpers for the per-host counter table.
// Each expects clk_i and rst_ni in the enclosing module.
`ifndef PER_HOST_TRAFFIC_COUNTER_TABLE_CORE_DEFINES_SVH
`define PER_HOST_TRAFFIC_COUNTER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define PHTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PHTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/phtc_pkg.sv =====
`default_nettype none
package phtc_pkg;

  localparam int ADDRESS_WIDTH     = 32;
  localparam int PEER_WIDTH        = 8;
  localparam int BYTES_WIDTH       = 32;
  localparam int TABLE_DEPTH_DEF   = 64;
  localparam int COUNTER_WIDTH_DEF = 64;

  typedef enum logic [1:0] {
    OP_ACCUM  = 2'd0,
    OP_REWIND = 2'd1,
    OP_NEXT   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_END  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDRESS_WIDTH-1:0] addr;
    logic [PEER_WIDTH-1:0]    peer;
  } key_t;

  // Memory port strobes from the sequencer.
  typedef struct packed {
    logic key_we;
    logic key_re;
    logic cnt_we;
    logic cnt_re;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/phtc_table.sv =====
`default_nettype none
module phtc_table #(
  parameter int TABLE_DEPTH   = phtc_pkg::TABLE_DEPTH_DEF,
  parameter int COUNTER_WIDTH = phtc_pkg::COUNTER_WIDTH_DEF,
  localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire phtc_pkg::mem_ctl_t         ctl_i,
  input  wire logic [IDXW-1:0]            key_waddr_i,
  input  wire logic [IDXW-1:0]            key_raddr_i,
  input  wire phtc_pkg::key_t             key_wdata_i,
  output phtc_pkg::key_t                  key_rdata_o,
  input  wire logic [IDXW-1:0]            cnt_waddr_i,
  input  wire logic [IDXW-1:0]            cnt_raddr_i,
  input  wire logic [2*COUNTER_WIDTH-1:0] cnt_wdata_i,
  output logic [2*COUNTER_WIDTH-1:0]      cnt_rdata_o
);
  import phtc_pkg::*;

  key_t                     key_mem [TABLE_DEPTH];
  logic [2*COUNTER_WIDTH-1:0] cnt_mem [TABLE_DEPTH];

  key_t                     key_rdata_q;
  logic [2*COUNTER_WIDTH-1:0] cnt_rdata_q;

  // key store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.key_we) begin
      key_mem[key_waddr_i] <= key_wdata_i;
    end
    if (ctl_i.key_re) begin
      key_rdata_q <= key_mem[key_raddr_i];
    end
  end

  // counter store: {received, sent}
  always_ff @(posedge clk_i) begin
    if (ctl_i.cnt_we) begin
      cnt_mem[cnt_waddr_i] <= cnt_wdata_i;
    end
    if (ctl_i.cnt_re) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr_i];
    end
  end

  assign key_rdata_o = key_rdata_q;
  assign cnt_rdata_o = cnt_rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/phtc_ctrl.sv =====
`default_nettype none
`include "per_host_traffic_counter_table_core_defines.svh"
module phtc_ctrl #(
  parameter int TABLE_DEPTH   = phtc_pkg::TABLE_DEPTH_DEF,
  parameter int COUNTER_WIDTH = phtc_pkg::COUNTER_WIDTH_DEF,
  localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire phtc_pkg::op_e                   op_i,
  input  wire phtc_pkg::key_t                  key_i,
  input  wire logic [phtc_pkg::BYTES_WIDTH-1:0] rx_i,
  input  wire logic [phtc_pkg::BYTES_WIDTH-1:0] tx_i,
  output logic                                 res_valid_o,
  input  wire logic                            res_ready_i,
  output phtc_pkg::status_e                    res_status_o,
  output phtc_pkg::key_t                       res_key_o,
  output logic [COUNTER_WIDTH-1:0]             res_rsum_o,
  output logic [COUNTER_WIDTH-1:0]             res_ssum_o,
  output logic                                 res_created_o,
  output phtc_pkg::mem_ctl_t                   mem_ctl_o,
  output logic [IDXW-1:0]                      key_waddr_o,
  output logic [IDXW-1:0]                      key_raddr_o,
  output phtc_pkg::key_t                       key_wdata_o,
  input  wire phtc_pkg::key_t                  key_rdata_i,
  output logic [IDXW-1:0]                      cnt_waddr_o,
  output logic [IDXW-1:0]                      cnt_raddr_o,
  output logic [2*COUNTER_WIDTH-1:0]           cnt_wdata_o,
  input  wire logic [2*COUNTER_WIDTH-1:0]      cnt_rdata_i
);
  import phtc_pkg::*;

  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int CW   = COUNTER_WIDTH;
  localparam int XW   = (CW > BYTES_WIDTH) ? CW : BYTES_WIDTH;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_LREAD  = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(TABLE_DEPTH);

  logic [2:0]             state_q, state_d;
  logic [CNTW-1:0]        count_q, count_d;
  logic [CNTW-1:0]        cursor_q, cursor_d;
  logic [CNTW-1:0]        sp_q, sp_d;
  logic                   pend_q, pend_d;
  logic [IDXW-1:0]        pend_slot_q, pend_slot_d;
  logic [IDXW-1:0]        slot_q, slot_d;
  logic                   made_q, made_d;
  logic [CNTW-1:0]        clr_q, clr_d;
  key_t                   key_q, key_d;
  logic [BYTES_WIDTH-1:0] rx_q, rx_d, tx_q, tx_d;

  status_e                rs_status_q, rs_status_d;
  key_t                   rs_key_q, rs_key_d;
  logic [CW-1:0]          rs_rsum_q, rs_rsum_d;
  logic [CW-1:0]          rs_ssum_q, rs_ssum_d;
  logic                   rs_created_q, rs_created_d;

  logic [CNTW-1:0]        sp_m1, count_m1, cursor_m2, clr_p1;
  logic [CW-1:0]          base_r, base_s;
  logic [XW-1:0]          wide_r, wide_s;
  logic                   hit;

  assign sp_m1     = sp_q - CNTW'(1);
  assign count_m1  = count_q - CNTW'(1);
  assign cursor_m2 = cursor_q - CNTW'(2);
  assign clr_p1    = clr_q + CNTW'(1);
  assign hit       = pend_q && (key_rdata_i == key_q);

  // new entries start from zero counters
  assign base_r = made_q ? '0 : cnt_rdata_i[2*CW-1:CW];
  assign base_s = made_q ? '0 : cnt_rdata_i[CW-1:0];
  assign wide_r = XW'(base_r) + XW'(rx_q);
  assign wide_s = XW'(base_s) + XW'(tx_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    sp_d         = sp_q;
    pend_d       = 1'b0;
    pend_slot_d  = pend_slot_q;
    slot_d       = slot_q;
    made_d       = made_q;
    clr_d        = clr_q;
    key_d        = key_q;
    rx_d         = rx_q;
    tx_d         = tx_q;
    rs_status_d  = rs_status_q;
    rs_key_d     = rs_key_q;
    rs_rsum_d    = rs_rsum_q;
    rs_ssum_d    = rs_ssum_q;
    rs_created_d = rs_created_q;
    mem_ctl_o    = '0;
    key_waddr_o  = slot_q;
    key_raddr_o  = sp_m1[IDXW-1:0];
    key_wdata_o  = key_q;
    cnt_waddr_o  = slot_q;
    cnt_raddr_o  = pend_slot_q;
    cnt_wdata_o  = {wide_r[CW-1:0], wide_s[CW-1:0]};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d        = key_i;
          rx_d         = rx_i;
          tx_d         = tx_i;
          rs_status_d  = ST_OK;
          rs_key_d     = '0;
          rs_rsum_d    = '0;
          rs_ssum_d    = '0;
          rs_created_d = 1'b0;
          case (op_i)
            OP_ACCUM: begin
              sp_d    = count_q;
              state_d = S_SEARCH;
            end
            OP_REWIND: begin
              if (count_q == '0) begin
                cursor_d    = '0;
                rs_status_d = ST_END;
                state_d     = S_OUT;
              end else begin
                cursor_d         = count_q;
                mem_ctl_o.key_re = 1'b1;
                mem_ctl_o.cnt_re = 1'b1;
                key_raddr_o      = count_m1[IDXW-1:0];
                cnt_raddr_o      = count_m1[IDXW-1:0];
                state_d          = S_LREAD;
              end
            end
            OP_NEXT: begin
              if (cursor_q <= CNTW'(1)) begin
                cursor_d    = '0;
                rs_status_d = ST_END;
                state_d     = S_OUT;
              end else begin
                cursor_d         = cursor_q - CNTW'(1);
                mem_ctl_o.key_re = 1'b1;
                mem_ctl_o.cnt_re = 1'b1;
                key_raddr_o      = cursor_m2[IDXW-1:0];
                cnt_raddr_o      = cursor_m2[IDXW-1:0];
                state_d          = S_LREAD;
              end
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = (count_q == '0) ? S_OUT : S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // newest first; each compare is made in the cycle after its key read
      S_SEARCH: begin
        if (hit) begin
          slot_d           = pend_slot_q;
          made_d           = 1'b0;
          mem_ctl_o.cnt_re = 1'b1;
          state_d          = S_ADD;
        end else if (sp_q != '0) begin
          mem_ctl_o.key_re = 1'b1;
          pend_d           = 1'b1;
          pend_slot_d      = sp_m1[IDXW-1:0];
          sp_d             = sp_m1;
        end else if (count_q == FULL_CNT) begin
          rs_status_d = ST_FULL;
          rs_key_d    = key_q;
          state_d     = S_OUT;
        end else begin
          slot_d  = count_q[IDXW-1:0];
          made_d  = 1'b1;
          state_d = S_ADD;
        end
      end

      S_ADD: begin
        mem_ctl_o.key_we = made_q;
        mem_ctl_o.cnt_we = 1'b1;
        if (made_q) begin
          count_d = count_q + CNTW'(1);
        end
        rs_status_d  = ST_OK;
        rs_key_d     = key_q;
        rs_rsum_d    = wide_r[CW-1:0];
        rs_ssum_d    = wide_s[CW-1:0];
        rs_created_d = made_q;
        state_d      = S_OUT;
      end

      S_LREAD: begin
        rs_status_d = ST_OK;
        rs_key_d    = key_rdata_i;
        rs_rsum_d   = cnt_rdata_i[2*CW-1:CW];
        rs_ssum_d   = cnt_rdata_i[CW-1:0];
        state_d     = S_OUT;
      end

      S_CLEAR: begin
        mem_ctl_o.cnt_we = 1'b1;
        cnt_waddr_o      = clr_q[IDXW-1:0];
        cnt_wdata_o      = '0;
        clr_d            = clr_p1;
        if (clr_p1 == count_q) begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      sp_q     <= '0;
      pend_q   <= 1'b0;
      clr_q    <= '0;
      made_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      sp_q     <= sp_d;
      pend_q   <= pend_d;
      clr_q    <= clr_d;
      made_q   <= made_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q  <= pend_slot_d;
    slot_q       <= slot_d;
    key_q        <= key_d;
    rx_q         <= rx_d;
    tx_q         <= tx_d;
    rs_status_q  <= rs_status_d;
    rs_key_q     <= rs_key_d;
    rs_rsum_q    <= rs_rsum_d;
    rs_ssum_q    <= rs_ssum_d;
    rs_created_q <= rs_created_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_OUT);
  assign res_status_o  = rs_status_q;
  assign res_key_o     = rs_key_q;
  assign res_rsum_o    = rs_rsum_q;
  assign res_ssum_o    = rs_ssum_q;
  assign res_created_o = rs_created_q;

  `PHTC_ASSERT_IMP(a_count_max, 1'b1, count_q <= FULL_CNT, "entry count above depth")
  `PHTC_ASSERT_IMP(a_cursor_max, 1'b1, cursor_q <= count_q, "cursor beyond entry count")
  `PHTC_ASSERT_IMP(a_alloc_room, state_q == S_ADD && made_q, count_q < FULL_CNT, "alloc on full")
  `PHTC_ASSERT_NXT(a_out_idle, state_q == S_OUT && res_ready_i, state_q == S_IDLE, "stuck in out")
  `PHTC_ASSERT_IMP(a_clear_range, state_q == S_CLEAR, clr_q < count_q, "clear sweep overran")

endmodule
`default_nettype wire

// ===== rtl/core/per_host_traffic_counter_table_core.sv =====
// Per-host traffic counter table. Entries are keyed by host address and peer
// class and hold received/sent byte counters that wrap at COUNTER_WIDTH bits.
// One word in gives exactly one word out. Keys and counters live in two
// single-port-read synchronous memories; a sequencer does read-modify-write,
// one word at a time. Accumulate walks the stored keys newest first, one key
// per cycle; a full table drops an update for a new key with status 1.
// Rewind and read-next each read one entry or report the end of the list;
// clear zeroes one counter row per cycle, entries kept. The memories need
// no clearing pass after reset: the fill count bounds every read. A finished
// result sits in the output register, so the sequencer goes back to
// accepting input while it waits to be taken.
`default_nettype none
module per_host_traffic_counter_table_core #(
  parameter int TABLE_DEPTH   = phtc_pkg::TABLE_DEPTH_DEF,
  parameter int COUNTER_WIDTH = phtc_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [1:0]                         operation_i,
  input  wire logic [phtc_pkg::ADDRESS_WIDTH-1:0] host_address_i,
  input  wire logic [phtc_pkg::PEER_WIDTH-1:0]    peer_class_i,
  input  wire logic [phtc_pkg::BYTES_WIDTH-1:0]   received_bytes_i,
  input  wire logic [phtc_pkg::BYTES_WIDTH-1:0]   sent_bytes_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [1:0]                              status_o,
  output logic [phtc_pkg::ADDRESS_WIDTH-1:0]      entry_address_o,
  output logic [phtc_pkg::PEER_WIDTH-1:0]         entry_peer_o,
  output logic [COUNTER_WIDTH-1:0]                received_sum_o,
  output logic [COUNTER_WIDTH-1:0]                sent_sum_o,
  output logic                                    created_o
);
  import phtc_pkg::*;

  localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  mem_ctl_t                   mem_ctl;
  logic [IDXW-1:0]            key_waddr, key_raddr, cnt_waddr, cnt_raddr;
  key_t                       key_wdata, key_rdata, in_key;
  logic [2*COUNTER_WIDTH-1:0] cnt_wdata, cnt_rdata;

  logic                       res_valid, res_ready, res_created;
  status_e                    res_status;
  key_t                       res_key;
  logic [COUNTER_WIDTH-1:0]   res_rsum, res_ssum;

  // output register
  logic                       out_valid_q;
  status_e                    out_status_q;
  key_t                       out_key_q;
  logic [COUNTER_WIDTH-1:0]   out_rsum_q, out_ssum_q;
  logic                       out_created_q;

  assign in_key.addr = host_address_i;
  assign in_key.peer = peer_class_i;

  phtc_ctrl #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_e'(operation_i)),
    .key_i        (in_key),
    .rx_i         (received_bytes_i),
    .tx_i         (sent_bytes_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_status_o (res_status),
    .res_key_o    (res_key),
    .res_rsum_o   (res_rsum),
    .res_ssum_o   (res_ssum),
    .res_created_o(res_created),
    .mem_ctl_o    (mem_ctl),
    .key_waddr_o  (key_waddr),
    .key_raddr_o  (key_raddr),
    .key_wdata_o  (key_wdata),
    .key_rdata_i  (key_rdata),
    .cnt_waddr_o  (cnt_waddr),
    .cnt_raddr_o  (cnt_raddr),
    .cnt_wdata_o  (cnt_wdata),
    .cnt_rdata_i  (cnt_rdata)
  );

  phtc_table #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_table (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .key_waddr_i(key_waddr),
    .key_raddr_i(key_raddr),
    .key_wdata_i(key_wdata),
    .key_rdata_o(key_rdata),
    .cnt_waddr_i(cnt_waddr),
    .cnt_raddr_i(cnt_raddr),
    .cnt_wdata_i(cnt_wdata),
    .cnt_rdata_o(cnt_rdata)
  );

  // take a result whenever the output slot is empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_status_q  <= res_status;
      out_key_q     <= res_key;
      out_rsum_q    <= res_rsum;
      out_ssum_q    <= res_ssum;
      out_created_q <= res_created;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign entry_address_o = out_key_q.addr;
  assign entry_peer_o    = out_key_q.peer;
  assign received_sum_o  = out_rsum_q;
  assign sent_sum_o      = out_ssum_q;
  assign created_o       = out_created_q;

endmodule
`default_nettype wire

// ===== sim/per_host_traffic_counter_table_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module per_host_traffic_counter_table_core_tb;
  import phtc_pkg::*;

  localparam int DEPTH      = TABLE_DEPTH_DEF;
  localparam int CW         = COUNTER_WIDTH_DEF;
  // Longest accumulate walks every stored key; pad it for the pipeline.
  localparam int SETTLE     = DEPTH + 16;
  localparam int STALL_LEN  = 600;
  localparam int WATCHDOG   = 4000;

  // One result word, as the block should return it.
  typedef struct packed {
    status_e                  status;
    logic [ADDRESS_WIDTH-1:0] addr;
    logic [PEER_WIDTH-1:0]    peer;
    logic [CW-1:0]            rx_sum;
    logic [CW-1:0]            tx_sum;
    logic                     created;
  } tally_t;

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     in_valid         = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               operation        = OP_CLEAR;
  logic [ADDRESS_WIDTH-1:0] host_address     = '0;
  logic [PEER_WIDTH-1:0]    peer_class       = '0;
  logic [BYTES_WIDTH-1:0]   received_bytes   = '0;
  logic [BYTES_WIDTH-1:0]   sent_bytes       = '0;
  logic                     out_valid_o;
  logic                     out_ready        = 1'b0;
  logic [1:0]               status_o;
  logic [ADDRESS_WIDTH-1:0] entry_address_o;
  logic [PEER_WIDTH-1:0]    entry_peer_o;
  logic [CW-1:0]            received_sum_o;
  logic [CW-1:0]            sent_sum_o;
  logic                     created_o;

  per_host_traffic_counter_table_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation),
    .host_address_i   (host_address),
    .peer_class_i     (peer_class),
    .received_bytes_i (received_bytes),
    .sent_bytes_i     (sent_bytes),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .status_o         (status_o),
    .entry_address_o  (entry_address_o),
    .entry_peer_o     (entry_peer_o),
    .received_sum_o   (received_sum_o),
    .sent_sum_o       (sent_sum_o),
    .created_o        (created_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the table: keys and counters in allocation order.
  logic [ADDRESS_WIDTH-1:0] shadow_addr [DEPTH];
  logic [PEER_WIDTH-1:0]    shadow_peer [DEPTH];
  logic [CW-1:0]            shadow_rx   [DEPTH];
  logic [CW-1:0]            shadow_tx   [DEPTH];
  int                       shadow_fill   = 0;
  int                       shadow_cursor = 0;  // 0 = end of list, else last slot read + 1

  tally_t pending_tallies [$];

  int  errors          = 0;
  int  words_sent      = 0;
  int  results_checked = 0;
  int  new_entries     = 0;
  int  dropped_updates = 0;
  int  list_ends       = 0;
  int  send_idle_pct   = 0;
  int  recv_idle_pct   = 0;
  bit  stall_request   = 1'b0;
  int  stall_left      = 0;
  int  quiet_cycles    = 0;

  function automatic tally_t slot_tally(int s);
    tally_t r;
    r         = '0;
    r.status  = ST_OK;
    r.addr    = shadow_addr[s];
    r.peer    = shadow_peer[s];
    r.rx_sum  = shadow_rx[s];
    r.tx_sum  = shadow_tx[s];
    return r;
  endfunction

  // Applies one word to the shadow table and returns the result it must produce.
  function automatic tally_t predict_tally(op_e op, logic [ADDRESS_WIDTH-1:0] a,
                                           logic [PEER_WIDTH-1:0] p,
                                           logic [BYTES_WIDTH-1:0] rx,
                                           logic [BYTES_WIDTH-1:0] tx);
    tally_t r;
    int     slot;
    int     i;
    r        = '0;
    r.status = ST_OK;
    case (op)
      OP_ACCUM: begin
        // Newest match wins, though keys are unique anyway.
        slot = -1;
        for (i = shadow_fill - 1; i >= 0; i--) begin
          if (slot < 0 && shadow_addr[i] == a && shadow_peer[i] == p) slot = i;
        end
        if (slot < 0 && shadow_fill == DEPTH) begin
          r.status = ST_FULL;
          r.addr   = a;
          r.peer   = p;
        end else begin
          if (slot < 0) begin
            slot              = shadow_fill;
            shadow_addr[slot] = a;
            shadow_peer[slot] = p;
            shadow_rx[slot]   = '0;
            shadow_tx[slot]   = '0;
            shadow_fill++;
          end
          shadow_rx[slot] = shadow_rx[slot] + {{(CW-BYTES_WIDTH){1'b0}}, rx};
          shadow_tx[slot] = shadow_tx[slot] + {{(CW-BYTES_WIDTH){1'b0}}, tx};
          r         = slot_tally(slot);
          r.created = (slot == shadow_fill - 1) && (shadow_addr[slot] == a) &&
                      (shadow_rx[slot] == {{(CW-BYTES_WIDTH){1'b0}}, rx}) &&
                      (shadow_tx[slot] == {{(CW-BYTES_WIDTH){1'b0}}, tx}) && 1'b0;
        end
      end
      OP_REWIND: begin
        if (shadow_fill == 0) begin
          shadow_cursor = 0;
          r.status      = ST_END;
        end else begin
          shadow_cursor = shadow_fill;
          r             = slot_tally(shadow_cursor - 1);
        end
      end
      OP_NEXT: begin
        if (shadow_cursor == 0) begin
          r.status = ST_END;
        end else begin
          shadow_cursor--;
          if (shadow_cursor == 0) r.status = ST_END;
          else r = slot_tally(shadow_cursor - 1);
        end
      end
      default: begin
        // Clear: counters go to zero, keys and cursor stay.
        for (i = 0; i < shadow_fill; i++) begin
          shadow_rx[i] = '0;
          shadow_tx[i] = '0;
        end
      end
    endcase
    return r;
  endfunction

  // Sends one word; valid stays up afterwards so back-to-back words need no
  // second assignment in the same step. Must be called at a rising edge.
  task automatic send_word(op_e op, logic [ADDRESS_WIDTH-1:0] a, logic [PEER_WIDTH-1:0] p,
                           logic [BYTES_WIDTH-1:0] rx, logic [BYTES_WIDTH-1:0] tx);
    tally_t r;
    int     fill_before;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    host_address   <= a;
    peer_class     <= p;
    received_bytes <= rx;
    sent_bytes     <= tx;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    fill_before = shadow_fill;
    r = predict_tally(op, a, p, rx, tx);
    // A grown table means this accumulate allocated the entry.
    if (op == OP_ACCUM && shadow_fill != fill_before) r.created = 1'b1;
    pending_tallies.push_back(r);
    words_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic pick_bytes(output logic [BYTES_WIDTH-1:0] v);
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
  endtask

  // Empty table: rewind and read-next both hit the end of list, then a clear.
  task automatic test_empty_table();
    send_word(OP_REWIND, '1, '1, '1, '1);
    send_word(OP_NEXT, '0, '0, '0, '0);
    send_word(OP_CLEAR, 32'hA5A5_5A5A, 8'h3C, '1, '0);
  endtask

  // Key and byte extremes, a repeat hit, and keys sharing one half.
  task automatic test_accumulate_extremes();
    send_word(OP_ACCUM, '0, '0, '0, '0);
    send_word(OP_ACCUM, '1, '1, '1, '1);
    send_word(OP_ACCUM, '1, '1, '1, '1);
    send_word(OP_ACCUM, '0, '1, 32'd1, 32'd2);
    send_word(OP_ACCUM, '1, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_ACCUM, '0, '0, '1, '0);
  endtask

  // Full walk past the end, then an insert in the middle of a walk.
  task automatic test_listing();
    int i;
    send_word(OP_REWIND, '0, '0, '0, '0);
    for (i = 0; i < 6; i++) send_word(OP_NEXT, '0, '0, '0, '0);
    send_word(OP_NEXT, '0, '0, '0, '0);
    send_word(OP_REWIND, '0, '0, '0, '0);
    send_word(OP_NEXT, '0, '0, '0, '0);
    send_word(OP_ACCUM, 32'h0102_0304, 8'h80, 32'd100, 32'd200);
    send_word(OP_NEXT, '0, '0, '0, '0);
    send_word(OP_REWIND, '0, '0, '0, '0);
  endtask

  // Clear keeps keys: a later hit is not a new entry and restarts from zero.
  task automatic test_clear();
    send_word(OP_CLEAR, '0, '0, '0, '0);
    send_word(OP_REWIND, '0, '0, '0, '0);
    send_word(OP_ACCUM, '1, '1, 32'd7, 32'd9);
  endtask

  // Fill every slot, then a dropped insert and a hit that still works.
  task automatic test_table_full();
    logic [BYTES_WIDTH-1:0] rx, tx;
    while (shadow_fill < DEPTH) begin
      pick_bytes(rx);
      pick_bytes(tx);
      send_word(OP_ACCUM, $urandom, 8'($urandom_range(255)), rx, tx);
    end
    send_word(OP_ACCUM, 32'hDEAD_0001, 8'h55, '1, '1);
    send_word(OP_ACCUM, shadow_addr[0], shadow_peer[0], 32'd1, 32'd1);
    send_word(OP_REWIND, '0, '0, '0, '0);
  endtask

  // Mostly hits on live keys and complete walks, with fresh keys and noise.
  task automatic test_random_traffic(int n);
    int                       done;
    int                       pick;
    int                       s;
    int                       walk;
    op_e                      op;
    logic [ADDRESS_WIDTH-1:0] a;
    logic [PEER_WIDTH-1:0]    p;
    logic [BYTES_WIDTH-1:0]   rx, tx;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        // Whole walk: rewind, then read-next until past the oldest entry,
        // with the odd accumulate slipped in.
        send_word(OP_REWIND, $urandom, 8'($urandom_range(255)), $urandom, $urandom);
        done++;
        for (walk = 0; walk <= shadow_cursor && done < n; walk++) begin
          if ($urandom_range(9) == 0 && shadow_fill > 0) begin
            s = $urandom_range(shadow_fill - 1);
            pick_bytes(rx);
            send_word(OP_ACCUM, shadow_addr[s], shadow_peer[s], rx, $urandom);
          end else begin
            send_word(OP_NEXT, $urandom, 8'($urandom_range(255)), $urandom, $urandom);
          end
          done++;
        end
      end else begin
        if (pick < 62)      op = OP_ACCUM;
        else if (pick < 70) op = OP_REWIND;
        else if (pick < 96) op = OP_NEXT;
        else                op = OP_CLEAR;
        a = $urandom;
        p = 8'($urandom_range(255));
        if (op == OP_ACCUM && shadow_fill > 0 && $urandom_range(99) < 85) begin
          s = $urandom_range(shadow_fill - 1);
          a = shadow_addr[s];
          p = shadow_peer[s];
          // Same host, other peer class: usually a new key.
          if ($urandom_range(9) == 0) p = 8'($urandom_range(255));
        end
        pick_bytes(rx);
        pick_bytes(tx);
        send_word(op, a, p, rx, tx);
        done++;
      end
    end
  endtask

  // Output held off for a long stretch while words keep coming, so the
  // block has to back up and drop in_ready.
  task automatic test_output_stall();
    int i;
    int s;
    stall_request = 1'b1;
    for (i = 0; i < 40; i++) begin
      s = $urandom_range(shadow_fill - 1);
      case (i % 4)
        0: send_word(OP_ACCUM, shadow_addr[s], shadow_peer[s], $urandom, $urandom);
        1: send_word(OP_REWIND, '0, '0, '0, '0);
        2: send_word(OP_NEXT, '0, '0, '0, '0);
        default: send_word(OP_CLEAR, '0, '0, '0, '0);
      endcase
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: check each accepted word, then pick the next ready.
  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t ns: result word with nothing expected, status %0d", $time, status_o);
        errors++;
      end else begin
        want = pending_tallies.pop_front();
        check_field("status", 64'(want.status), 64'(status_o));
        check_field("entry_address", 64'(want.addr), 64'(entry_address_o));
        check_field("entry_peer", 64'(want.peer), 64'(entry_peer_o));
        check_field("received_sum", 64'(want.rx_sum), 64'(received_sum_o));
        check_field("sent_sum", 64'(want.tx_sum), 64'(sent_sum_o));
        check_field("created", 64'(want.created), 64'(created_o));
        results_checked++;
        if (want.created)          new_entries++;
        if (want.status == ST_FULL) dropped_updates++;
        if (want.status == ST_END)  list_ends++;
      end
    end
    if (stall_request) begin
      stall_request = 1'b0;
      stall_left    = STALL_LEN;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hang detector: too long with no word moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: sender mostly busy, receiver often stalling.
    send_idle_pct = 11;
    recv_idle_pct = 70;
    test_empty_table();
    test_accumulate_extremes();
    test_listing();
    test_clear();
    test_random_traffic(300);
    test_table_full();
    test_random_traffic(300);
    wait_drain();

    // Phase 2: the other way round, plus one long output stall.
    send_idle_pct = 70;
    recv_idle_pct = 11;
    test_random_traffic(600);
    test_output_stall();
    wait_drain();

    // Phase 3: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(550);
    wait_drain();

    $display("%0d words sent, %0d results checked: %0d new entries, %0d dropped on full table,",
             words_sent, results_checked, new_entries, dropped_updates);
    $display("%0d end-of-list reads; empty table, walks with inserts, clear, long output stall",
             list_ends);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
